FILE: rtl/usan_pkg.sv
// Shared types, constants and the lead byte classifier for the UTF-8 byte sanitiser.
package usan_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int RUN_MAX    = 4;
   localparam int PEND_DEPTH = 3;

   // Register decode uses the word address bit of paddr
   localparam logic CSR_REG_REPL = 1'b0;

   localparam logic [BYTE_W-1:0] REPL_RESET = 8'h3F;

   // Bit patterns of lead and continuation bytes
   localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
   localparam logic [BYTE_W-1:0] MASK_TOP3  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
   localparam logic [BYTE_W-1:0] MASK_TOP4  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
   localparam logic [BYTE_W-1:0] MASK_TOP5  = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
   localparam logic [BYTE_W-1:0] MASK_TOP2  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;

   // Sequence lengths; LEN_BAD marks an illegal lead byte
   localparam logic [2:0] LEN_BAD   = 3'd0;
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // One queued run of output bytes: last_idx is the index of its final byte
   typedef struct packed {
      logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
      logic [1:0]                     last_idx;
      logic                           text_end;
   } usan_cmd_type;

   function automatic logic [2:0] lead_len_f(input logic [BYTE_W-1:0] b);
      logic [2:0] len;
      if (b <= ASCII_MAX) len = LEN_ONE;
      else if ((b & MASK_TOP3) == LEAD2_PAT) len = LEN_TWO;
      else if ((b & MASK_TOP4) == LEAD3_PAT) len = LEN_THREE;
      else if ((b & MASK_TOP5) == LEAD4_PAT) len = LEN_FOUR;
      else len = LEN_BAD;
      return len;
   endfunction

   function automatic logic is_cont_f(input logic [BYTE_W-1:0] b);
      return (b & MASK_TOP2) == CONT_PAT;
   endfunction

endpackage

FILE: rtl/usan_if.sv
// Stream interfaces for the sanitiser's byte input and byte output channels.
interface usan_req_if import usan_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              text_end;

   modport source (output valid, in_byte, text_end, input ready);
   modport sink   (input valid, in_byte, text_end, output ready);
endinterface

interface usan_rsp_if import usan_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              run_last;
   logic              text_last;

   modport source (output valid, out_byte, run_last, text_last, input ready);
   modport sink   (input valid, out_byte, run_last, text_last, output ready);
endinterface

FILE: rtl/utf8_byte_sanitizer.sv
// UTF-8 byte sanitiser: takes raw text bytes and returns bytes with invalid
// or truncated sequences replaced by one replacement byte each.
// req_chan: one raw byte per transfer, text_end flags the final byte of a text.
// rsp_chan: one output byte per transfer; run_last marks the last byte released
//   by an input byte, text_last the final output byte of a text.
// Multi-byte sequences are held in the front end until complete, then
// released as a run of up to four bytes; a lead or inner continuation byte
// releases nothing unless it is the final byte of a text.
// The first byte of a run passes through the run queue and then the output
// register before it is offered. Throughput: one input byte and one output
// byte per cycle while the queue has room and the receiver is ready; the
// back end emits one byte a cycle while the receiver does not stall.
// The front end takes input while the run queue (QUEUE_DEPTH runs) has room,
// so a stalled receiver first fills the output register, then the queue, and
// only then pulls req_chan.ready low.
// Reset clears the open sequence, the queue and the output register, and sets
// the replacement byte to '?'. The user writes the replacement byte over the
// APB port at address 0 only while the block is idle; this is not enforced.
module utf8_byte_sanitizer import usan_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   usan_req_if.sink              req_chan,
   usan_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [BYTE_W-1:0] repl_ff;
   logic              csr_write;
   logic              push;
   logic              pop;
   logic              full;
   logic              empty;
   usan_cmd_type      push_cmd;
   usan_cmd_type      head_cmd;

   // Configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_W-1] == CSR_REG_REPL);
   assign prdata    = {(CSR_DATA_W - BYTE_W)'(0), repl_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_RESET;
      end else if (csr_write) begin
         repl_ff <= pwdata[BYTE_W-1:0];
      end
   end

   usan_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .repl_byte  (repl_ff),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   usan_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty)
   );

   usan_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/usan_front.sv
// Front end: accepts input bytes, tracks the open sequence and queues output runs.
module usan_front import usan_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   usan_req_if.sink          req_chan,
   input  logic [BYTE_W-1:0] repl_byte,
   input  logic              queue_full,
   output logic              push,
   output usan_cmd_type      push_cmd
);

   logic [2:0]        exp_len_ff, exp_len_in;
   logic [1:0]        gathered_ff, gathered_in;
   logic              ok_ff, ok_in;
   logic [BYTE_W-1:0] pend_ff [PEND_DEPTH];

   logic              accept;
   logic [BYTE_W-1:0] b;
   logic              last;
   logic [2:0]        lead_len;
   logic              ok_next;
   logic              complete;
   logic              push_raw;
   logic              pend_wr;
   logic [1:0]        pend_idx;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.in_byte;
   assign last           = req_chan.text_end;
   assign lead_len       = lead_len_f(b);
   assign ok_next        = ok_ff && is_cont_f(b);
   assign complete       = (3'({1'b0, gathered_ff}) + 3'd1) >= exp_len_ff;

   // Classify the byte and build the run it releases, if any
   always_comb begin
      exp_len_in  = exp_len_ff;
      gathered_in = gathered_ff;
      ok_in       = ok_ff;
      pend_wr     = 1'b0;
      pend_idx    = gathered_ff;
      push_raw    = 1'b0;
      push_cmd    = '0;
      push_cmd.text_end = last;

      if (exp_len_ff == LEN_BAD) begin
         case (lead_len)
            LEN_ONE: begin
               push_raw          = 1'b1;
               push_cmd.bytes[0] = b;
            end
            LEN_BAD: begin
               push_raw          = 1'b1;
               push_cmd.bytes[0] = repl_byte;
            end
            default: begin
               // multi-byte lead: open a sequence
               pend_wr     = 1'b1;
               pend_idx    = 2'd0;
               exp_len_in  = lead_len;
               gathered_in = 2'd1;
               ok_in       = 1'b1;
               if (last) begin
                  push_raw          = 1'b1;
                  push_cmd.bytes[0] = repl_byte;
               end
            end
         endcase
      end else if (complete) begin
         push_raw = 1'b1;
         if (ok_next) begin
            for (int i = 0; i < PEND_DEPTH; i++) begin
               push_cmd.bytes[i] = (2'(i) < gathered_ff) ? pend_ff[i] : b;
            end
            push_cmd.bytes[RUN_MAX-1] = b;
            push_cmd.last_idx         = gathered_ff;
         end else begin
            push_cmd.bytes[0] = repl_byte;
         end
         exp_len_in  = LEN_BAD;
         gathered_in = 2'd0;
         ok_in       = 1'b1;
      end else begin
         // inner continuation: store and keep gathering
         pend_wr     = 1'b1;
         gathered_in = gathered_ff + 2'd1;
         ok_in       = ok_next;
         if (last) begin
            push_raw          = 1'b1;
            push_cmd.bytes[0] = repl_byte;
         end
      end

      // end of text closes whatever is open
      if (last) begin
         exp_len_in  = LEN_BAD;
         gathered_in = 2'd0;
         ok_in       = 1'b1;
      end
   end

   assign push = accept && push_raw;

   // Sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff  <= LEN_BAD;
         gathered_ff <= 2'd0;
         ok_ff       <= 1'b1;
      end else if (accept) begin
         exp_len_ff  <= exp_len_in;
         gathered_ff <= gathered_in;
         ok_ff       <= ok_in;
      end
   end

   // Pending bytes of the open sequence
   always_ff @(posedge clock) begin
      if (accept && pend_wr && (pend_idx != 2'd3)) begin
         pend_ff[pend_idx] <= b;
      end
   end

endmodule

FILE: rtl/usan_queue.sv
// Short queue of output runs between the front end and the back end.
module usan_queue import usan_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  usan_cmd_type push_cmd,
   output logic         full,
   input  logic         pop,
   output usan_cmd_type head_cmd,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   usan_cmd_type     store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = store_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/usan_back.sv
// Back end: unrolls queued runs into single output bytes through an output register.
module usan_back import usan_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  usan_cmd_type head_cmd,
   input  logic         empty,
   output logic         pop,
   usan_rsp_if.source   rsp_chan
);

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              run_last_ff;
   logic              text_last_ff;
   logic              load;
   logic              run_end;

   assign load    = !empty && (!valid_ff || rsp_chan.ready);
   assign run_end = idx_ff == head_cmd.last_idx;
   assign pop     = load && run_end;

   always_comb begin
      idx_in = idx_ff;
      if (load) idx_in = run_end ? 2'd0 : idx_ff + 2'd1;
      if (load) valid_in = 1'b1;
      else if (rsp_chan.ready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff      <= head_cmd.bytes[idx_ff];
         run_last_ff  <= run_end;
         text_last_ff <= run_end && head_cmd.text_end;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_byte  = byte_ff;
   assign rsp_chan.run_last  = run_last_ff;
   assign rsp_chan.text_last = text_last_ff;

endmodule

FILE: rtl/usan_checker.sv
// Port-level checks for the UTF-8 byte sanitiser and their binding to the top level.
module usan_checker import usan_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [BYTE_W-1:0]     rsp_out_byte,
   input logic                  rsp_run_last,
   input logic                  rsp_text_last,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   input logic [CSR_DATA_W-1:0] prdata
);

   // A stalled output byte holds with its flags
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_text_last))
      else $error("output transfer changed while stalled");

   // The end of a text always closes a run
   a_text_last_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_last |-> rsp_run_last)
      else $error("text_last without run_last");

   // Nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   // Replacement byte reads back as written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && (paddr[CSR_ADDR_W-1] == CSR_REG_REPL)
      |=> prdata == {(CSR_DATA_W - BYTE_W)'(0), $past(pwdata[BYTE_W-1:0])})
      else $error("replacement byte readback mismatch");

endmodule

bind utf8_byte_sanitizer usan_checker u_usan_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_run_last  (rsp_chan.run_last),
   .rsp_text_last (rsp_chan.text_last),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr),
   .pwdata        (pwdata),
   .prdata        (prdata)
);
